@@ sv/attn2_pkg.sv @@
`timescale 1ns / 1ps
package attn2_pkg;

   localparam int EMBED_DIM     = 4;
   localparam int FRAC_BITS_DEF = 14;
   localparam int IN_W          = 16;
   localparam int OUT_W         = 16;
   localparam int WEIGHT_BITS   = 15;
   localparam int QUOT_W        = 16;

   // weight tables in hundredths, row r gives output element r
   localparam int ROM_QUERY [EMBED_DIM][EMBED_DIM] = '{
      '{ 50, -25,  10,  30},
      '{-15,  60, -20,   5},
      '{ 20,  10,  45, -30},
      '{ -5,  35,  25,  55}
   };
   localparam int ROM_KEY [EMBED_DIM][EMBED_DIM] = '{
      '{ 40,  15, -10,  20},
      '{  5, -50,  30, -10},
      '{-20,  25,  35,  10},
      '{ 30,  -5,  15, -45}
   };
   localparam int ROM_VALUE [EMBED_DIM][EMBED_DIM] = '{
      '{ 30,  20,  10, -15},
      '{-10,  40, -25,   5},
      '{ 15, -30,  50,  20},
      '{  5,  10, -20,  35}
   };

   // hundredths to fixed point, half away from zero
   function automatic int rom_fixed(input int hundredths, input int frac);
      int n;
      begin
         n = hundredths * (1 << frac);
         if (n >= 0) begin
            rom_fixed = (n + 50) / 100;
         end else begin
            rom_fixed = -((-n + 50) / 100);
         end
      end
   endfunction

endpackage

@@ sv/attn2_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider: quot = (term * 2^15 + total / 2) / total.
// Four register stages, four quotient bits per stage. Needs term <= total.
module attn2_div #(
   parameter int FRAC_BITS = attn2_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic [FRAC_BITS:0]            term,
   input  logic [FRAC_BITS+1:0]          total,
   output logic [attn2_pkg::QUOT_W-1:0]  quot
);
   import attn2_pkg::*;

   localparam int DW    = FRAC_BITS + 2;
   localparam int NW    = FRAC_BITS + 16;
   localparam int NSTG  = 4;
   localparam int BPS   = QUOT_W / NSTG;

   logic [NW-1:0]     numer;
   logic [DW-1:0]     rem_src [NSTG];
   logic [DW-1:0]     den_src [NSTG];
   logic [QUOT_W-1:0] low_src [NSTG];
   logic [QUOT_W-1:0] q_src   [NSTG];

   logic [DW-1:0]     rem_in [NSTG];
   logic [QUOT_W-1:0] low_in [NSTG];
   logic [QUOT_W-1:0] q_in   [NSTG];

   logic [DW-1:0]     rem_ff [NSTG];
   logic [DW-1:0]     den_ff [NSTG];
   logic [QUOT_W-1:0] low_ff [NSTG];
   logic [QUOT_W-1:0] q_ff   [NSTG];

   assign numer = (NW'(term) << WEIGHT_BITS) + NW'(total >> 1);

   // quotient is below 2^16, so the top part of the numerator is already below total
   always_comb begin
      rem_src[0] = DW'(numer[NW-1:QUOT_W]);
      den_src[0] = total;
      low_src[0] = numer[QUOT_W-1:0];
      q_src[0]   = '0;
      for (int s = 1; s < NSTG; s++) begin
         rem_src[s] = rem_ff[s-1];
         den_src[s] = den_ff[s-1];
         low_src[s] = low_ff[s-1];
         q_src[s]   = q_ff[s-1];
      end
   end

   always_comb begin
      logic [DW:0]       trial;
      logic [DW-1:0]     rem;
      logic [QUOT_W-1:0] low;
      logic [QUOT_W-1:0] q;
      for (int s = 0; s < NSTG; s++) begin
         rem = rem_src[s];
         low = low_src[s];
         q   = q_src[s];
         for (int j = 0; j < BPS; j++) begin
            trial = {rem, low[QUOT_W-1]};
            low   = low << 1;
            if (trial >= (DW+1)'(den_src[s])) begin
               rem = DW'(trial - (DW+1)'(den_src[s]));
               q   = {q[QUOT_W-2:0], 1'b1};
            end else begin
               rem = trial[DW-1:0];
               q   = {q[QUOT_W-2:0], 1'b0};
            end
         end
         rem_in[s] = rem;
         low_in[s] = low;
         q_in[s]   = q;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NSTG; s++) begin
         rem_ff[s] <= rem_in[s];
         den_ff[s] <= den_src[s];
         low_ff[s] <= low_in[s];
         q_ff[s]   <= q_in[s];
      end
   end

   assign quot = q_ff[NSTG-1];

endmodule

@@ sv/attention_head_two_token.sv @@
`timescale 1ns / 1ps
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+---------------------------
// request   | req_tok0_e0..e3, req_tok1_e0..e3        | start high, busy low
// response  | rsp_head_e0..e3, rsp_weight_self/other  | rsp_valid, one cycle
//
// Eleven-stage pipeline: one transaction accepted every cycle, busy stays low.
// The two weight divisions (four stages each, four quotient bits per stage)
// take four of those stages.
// Synchronous reset clears the valid bits only; data registers are not reset.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module attention_head_two_token #(
   parameter int FRAC_BITS = attn2_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [attn2_pkg::IN_W-1:0]     req_tok0_e0,
   input  logic signed [attn2_pkg::IN_W-1:0]     req_tok0_e1,
   input  logic signed [attn2_pkg::IN_W-1:0]     req_tok0_e2,
   input  logic signed [attn2_pkg::IN_W-1:0]     req_tok0_e3,
   input  logic signed [attn2_pkg::IN_W-1:0]     req_tok1_e0,
   input  logic signed [attn2_pkg::IN_W-1:0]     req_tok1_e1,
   input  logic signed [attn2_pkg::IN_W-1:0]     req_tok1_e2,
   input  logic signed [attn2_pkg::IN_W-1:0]     req_tok1_e3,
   output logic                                  rsp_valid,
   output logic signed [attn2_pkg::OUT_W-1:0]    rsp_head_e0,
   output logic signed [attn2_pkg::OUT_W-1:0]    rsp_head_e1,
   output logic signed [attn2_pkg::OUT_W-1:0]    rsp_head_e2,
   output logic signed [attn2_pkg::OUT_W-1:0]    rsp_head_e3,
   output logic        [attn2_pkg::OUT_W-1:0]    rsp_weight_self,
   output logic        [attn2_pkg::OUT_W-1:0]    rsp_weight_other
);
   import attn2_pkg::*;

   localparam int ROMW  = FRAC_BITS + 2;
   localparam int PRW   = ROMW + IN_W;
   localparam int AW    = PRW + 2;
   localparam int PW    = 18;
   localparam int SPW   = 2 * PW;
   localparam int SAW   = SPW + 2;
   localparam int SW    = SAW - FRAC_BITS;
   localparam int XW    = SAW + 2;
   localparam int TW    = FRAC_BITS + 1;
   localparam int DW    = FRAC_BITS + 2;
   localparam int HPW   = PW + QUOT_W + 1;
   localparam int HSW   = HPW + 1;
   localparam int NPROJ = 5;
   localparam int NSTG  = 11;
   localparam int VDLY  = 7;

   localparam int PJ_Q  = 0;
   localparam int PJ_K0 = 1;
   localparam int PJ_K1 = 2;
   localparam int PJ_V0 = 3;
   localparam int PJ_V1 = 4;

   localparam logic [AW-1:0]         P_HALF = AW'(1) << (FRAC_BITS - 1);
   localparam logic [SAW-1:0]        S_HALF = SAW'(1) << FRAC_BITS;
   localparam logic signed [XW-1:0]  ONE_X  = XW'(1) << FRAC_BITS;
   localparam logic [HSW-1:0]        H_HALF = HSW'(1) << (WEIGHT_BITS - 1);
   localparam logic signed [HSW-1:0] SAT_HI = HSW'(32767);
   localparam logic signed [HSW-1:0] SAT_LO = -HSW'(32768);

   logic signed [IN_W-1:0] tok0 [EMBED_DIM];
   logic signed [IN_W-1:0] tok1 [EMBED_DIM];

   logic [NSTG-1:0] vld_in, vld_ff;

   logic signed [PRW-1:0] prod_in [NPROJ][EMBED_DIM][EMBED_DIM];
   logic signed [PRW-1:0] prod_ff [NPROJ][EMBED_DIM][EMBED_DIM];
   logic signed [PW-1:0]  proj_in [NPROJ][EMBED_DIM];
   logic signed [PW-1:0]  proj_ff [NPROJ][EMBED_DIM];
   logic signed [SPW-1:0] sp_in   [2][EMBED_DIM];
   logic signed [SPW-1:0] sp_ff   [2][EMBED_DIM];
   logic signed [SW-1:0]  score_in [2];
   logic signed [SW-1:0]  score_ff [2];
   logic [TW-1:0]         term_in [2];
   logic [TW-1:0]         term_ff [2];
   logic [DW-1:0]         total_in, total_ff;
   logic [QUOT_W-1:0]     wgt_self, wgt_other;
   logic signed [PW-1:0]  v0_dly_ff [VDLY][EMBED_DIM];
   logic signed [PW-1:0]  v1_dly_ff [VDLY][EMBED_DIM];
   logic signed [HPW-1:0] hp_in [2][EMBED_DIM];
   logic signed [HPW-1:0] hp_ff [2][EMBED_DIM];
   logic [QUOT_W-1:0]     wself_dly_ff, wother_dly_ff;
   logic signed [OUT_W-1:0] head_in [EMBED_DIM];
   logic signed [OUT_W-1:0] head_ff [EMBED_DIM];
   logic [OUT_W-1:0]      wself_ff, wother_ff;

   assign tok0[0] = req_tok0_e0;
   assign tok0[1] = req_tok0_e1;
   assign tok0[2] = req_tok0_e2;
   assign tok0[3] = req_tok0_e3;
   assign tok1[0] = req_tok1_e0;
   assign tok1[1] = req_tok1_e1;
   assign tok1[2] = req_tok1_e2;
   assign tok1[3] = req_tok1_e3;

   assign busy = 1'b0;

   assign vld_in = {vld_ff[NSTG-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: constant-coefficient products
   always_comb begin
      logic signed [ROMW-1:0] rq, rk, rv;
      for (int r = 0; r < EMBED_DIM; r++) begin
         for (int c = 0; c < EMBED_DIM; c++) begin
            rq = ROMW'(rom_fixed(ROM_QUERY[r][c], FRAC_BITS));
            rk = ROMW'(rom_fixed(ROM_KEY[r][c], FRAC_BITS));
            rv = ROMW'(rom_fixed(ROM_VALUE[r][c], FRAC_BITS));
            prod_in[PJ_Q][r][c]  = PRW'(tok0[c]) * PRW'(rq);
            prod_in[PJ_K0][r][c] = PRW'(tok0[c]) * PRW'(rk);
            prod_in[PJ_K1][r][c] = PRW'(tok1[c]) * PRW'(rk);
            prod_in[PJ_V0][r][c] = PRW'(tok0[c]) * PRW'(rv);
            prod_in[PJ_V1][r][c] = PRW'(tok1[c]) * PRW'(rv);
         end
      end
   end

   // stage 2: projection sums, round to FRAC_BITS
   always_comb begin
      logic signed [AW-1:0] acc;
      for (int m = 0; m < NPROJ; m++) begin
         for (int r = 0; r < EMBED_DIM; r++) begin
            acc = $signed(P_HALF);
            for (int c = 0; c < EMBED_DIM; c++) begin
               acc = acc + AW'(prod_ff[m][r][c]);
            end
            proj_in[m][r] = PW'(acc >>> FRAC_BITS);
         end
      end
   end

   // stage 3: score products
   always_comb begin
      for (int i = 0; i < EMBED_DIM; i++) begin
         sp_in[0][i] = SPW'(proj_ff[PJ_Q][i]) * SPW'(proj_ff[PJ_K0][i]);
         sp_in[1][i] = SPW'(proj_ff[PJ_Q][i]) * SPW'(proj_ff[PJ_K1][i]);
      end
   end

   // stage 4: scores, the extra shift folds in the scale of one half
   always_comb begin
      logic signed [SAW-1:0] sacc;
      for (int j = 0; j < 2; j++) begin
         sacc = $signed(S_HALF);
         for (int i = 0; i < EMBED_DIM; i++) begin
            sacc = sacc + SAW'(sp_ff[j][i]);
         end
         score_in[j] = SW'(sacc >>> (FRAC_BITS + 1));
      end
   end

   // stage 5: clipped linear exp and sum; the larger score always gives exactly one
   always_comb begin
      logic signed [SW-1:0] top;
      logic signed [XW-1:0] tv;
      logic [DW-1:0]        sum;
      top = (score_ff[0] > score_ff[1]) ? score_ff[0] : score_ff[1];
      for (int j = 0; j < 2; j++) begin
         tv = ONE_X + XW'(score_ff[j]) - XW'(top);
         term_in[j] = tv[XW-1] ? '0 : tv[TW-1:0];
      end
      sum = DW'(term_in[0]) + DW'(term_in[1]);
      total_in = (sum == '0) ? DW'(ONE_X[DW-1:0]) : sum;
   end

   // stages 6 to 9: weight division
   attn2_div #(.FRAC_BITS(FRAC_BITS)) u_div_self (
      .clock (clock),
      .term  (term_ff[0]),
      .total (total_ff),
      .quot  (wgt_self)
   );

   attn2_div #(.FRAC_BITS(FRAC_BITS)) u_div_other (
      .clock (clock),
      .term  (term_ff[1]),
      .total (total_ff),
      .quot  (wgt_other)
   );

   // stage 10: blend products
   always_comb begin
      for (int i = 0; i < EMBED_DIM; i++) begin
         hp_in[0][i] = HPW'($signed({1'b0, wgt_self}))  * HPW'(v0_dly_ff[VDLY-1][i]);
         hp_in[1][i] = HPW'($signed({1'b0, wgt_other})) * HPW'(v1_dly_ff[VDLY-1][i]);
      end
   end

   // stage 11: sum, round by 2^15, saturate
   always_comb begin
      logic signed [HSW-1:0] hs;
      for (int i = 0; i < EMBED_DIM; i++) begin
         hs = HSW'(hp_ff[0][i]) + HSW'(hp_ff[1][i]) + $signed(H_HALF);
         hs = hs >>> WEIGHT_BITS;
         if (hs > SAT_HI) begin
            head_in[i] = SAT_HI[OUT_W-1:0];
         end else if (hs < SAT_LO) begin
            head_in[i] = SAT_LO[OUT_W-1:0];
         end else begin
            head_in[i] = hs[OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      proj_ff  <= proj_in;
      sp_ff    <= sp_in;
      score_ff <= score_in;
      term_ff  <= term_in;
      total_ff <= total_in;
      v0_dly_ff[0] <= proj_ff[PJ_V0];
      v1_dly_ff[0] <= proj_ff[PJ_V1];
      for (int d = 1; d < VDLY; d++) begin
         v0_dly_ff[d] <= v0_dly_ff[d-1];
         v1_dly_ff[d] <= v1_dly_ff[d-1];
      end
      hp_ff         <= hp_in;
      wself_dly_ff  <= wgt_self;
      wother_dly_ff <= wgt_other;
      head_ff       <= head_in;
      wself_ff      <= OUT_W'(wself_dly_ff);
      wother_ff     <= OUT_W'(wother_dly_ff);
   end

   assign rsp_valid        = vld_ff[NSTG-1];
   assign rsp_head_e0      = head_ff[0];
   assign rsp_head_e1      = head_ff[1];
   assign rsp_head_e2      = head_ff[2];
   assign rsp_head_e3      = head_ff[3];
   assign rsp_weight_self  = wself_ff;
   assign rsp_weight_other = wother_ff;

endmodule

@@ sv/attn2_checker.sv @@
`timescale 1ns / 1ps
module attn2_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [attn2_pkg::OUT_W-1:0]        rsp_weight_self,
   input logic [attn2_pkg::OUT_W-1:0]        rsp_weight_other
);
   import attn2_pkg::*;

   // every accepted transaction gives a response at the end of the pipeline
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##11 rsp_valid)
      else $error("response missing after accepted transaction");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##11 !rsp_valid)
      else $error("response without a transaction");

   // the larger score gives a term of one, so its weight is at least one half
   a_dominant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weight_self >= 16'd16384 || rsp_weight_other >= 16'd16384))
      else $error("no dominant attention weight");

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((17'(rsp_weight_self) + 17'(rsp_weight_other) >= 17'd32767) &&
                     (17'(rsp_weight_self) + 17'(rsp_weight_other) <= 17'd32769)))
      else $error("attention weights do not sum to one");

endmodule

bind attention_head_two_token attn2_checker u_attn2_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_weight_self  (rsp_weight_self),
   .rsp_weight_other (rsp_weight_other)
);

@@ sim/attention_head_two_token_tb.sv @@
`timescale 1ns / 1ps
module attention_head_two_token_tb;
   import attn2_pkg::*;

   localparam int FB = FRAC_BITS_DEF;

   typedef struct {
      shortint tok0 [EMBED_DIM];
      shortint tok1 [EMBED_DIM];
   } token_pair_type;

   typedef struct {
      shortint       head [EMBED_DIM];
      bit [15:0]     w_self;
      bit [15:0]     w_other;
   } attn_out_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [IN_W-1:0] tok0 [EMBED_DIM];
   logic signed [IN_W-1:0] tok1 [EMBED_DIM];
   logic rsp_valid;
   logic signed [OUT_W-1:0] head [EMBED_DIM];
   logic [OUT_W-1:0] weight_self, weight_other;

   attn_out_type expected_q [$];
   int errors = 0;

   attention_head_two_token DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_tok0_e0(tok0[0]), .req_tok0_e1(tok0[1]),
      .req_tok0_e2(tok0[2]), .req_tok0_e3(tok0[3]),
      .req_tok1_e0(tok1[0]), .req_tok1_e1(tok1[1]),
      .req_tok1_e2(tok1[2]), .req_tok1_e3(tok1[3]),
      .rsp_valid(rsp_valid),
      .rsp_head_e0(head[0]), .rsp_head_e1(head[1]),
      .rsp_head_e2(head[2]), .rsp_head_e3(head[3]),
      .rsp_weight_self(weight_self), .rsp_weight_other(weight_other)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

   // hundredths to fixed point, half away from zero
   function automatic longint hundredths_to_fix(int h);
      longint n;
      n = longint'(h) * (longint'(1) << FB);
      return (n >= 0) ? (n + 50) / 100 : -((-n + 50) / 100);
   endfunction

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic attn_out_type attend(token_pair_type p);
      attn_out_type r;
      longint q [EMBED_DIM], k0 [EMBED_DIM], k1 [EMBED_DIM];
      longint v0 [EMBED_DIM], v1 [EMBED_DIM];
      longint aq, ak0, ak1, av0, av1, sa, sb, top, ta, tb, total, wa, wb, acc;
      for (int i = 0; i < EMBED_DIM; i++) begin
         aq = 0; ak0 = 0; ak1 = 0; av0 = 0; av1 = 0;
         for (int j = 0; j < EMBED_DIM; j++) begin
            aq  += hundredths_to_fix(ROM_QUERY[i][j]) * p.tok0[j];
            ak0 += hundredths_to_fix(ROM_KEY[i][j])   * p.tok0[j];
            ak1 += hundredths_to_fix(ROM_KEY[i][j])   * p.tok1[j];
            av0 += hundredths_to_fix(ROM_VALUE[i][j]) * p.tok0[j];
            av1 += hundredths_to_fix(ROM_VALUE[i][j]) * p.tok1[j];
         end
         q[i]  = round_shift(aq, FB);
         k0[i] = round_shift(ak0, FB);
         k1[i] = round_shift(ak1, FB);
         v0[i] = round_shift(av0, FB);
         v1[i] = round_shift(av1, FB);
      end
      sa = 0; sb = 0;
      for (int i = 0; i < EMBED_DIM; i++) begin
         sa += q[i] * k0[i];
         sb += q[i] * k1[i];
      end
      // the shift by one extra bit is the scale of one half
      sa = round_shift(sa, FB + 1);
      sb = round_shift(sb, FB + 1);
      top = (sa > sb) ? sa : sb;
      ta = (longint'(1) << FB) + sa - top;
      tb = (longint'(1) << FB) + sb - top;
      if (ta < 0) ta = 0;
      if (tb < 0) tb = 0;
      total = ta + tb;
      if (total <= 0) total = longint'(1) << FB;
      wa = ((ta << WEIGHT_BITS) + total / 2) / total;
      wb = ((tb << WEIGHT_BITS) + total / 2) / total;
      for (int i = 0; i < EMBED_DIM; i++) begin
         acc = round_shift(wa * v0[i] + wb * v1[i], WEIGHT_BITS);
         if (acc > 32767) acc = 32767;
         if (acc < -32768) acc = -32768;
         r.head[i] = shortint'(acc);
      end
      r.w_self  = wa[15:0];
      r.w_other = wb[15:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
      errors++;
   endtask

   // response checker
   always @(posedge clock) begin
      attn_out_type e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            e = expected_q.pop_front();
            for (int i = 0; i < EMBED_DIM; i++)
               if (head[i] !== e.head[i])
                  report_mismatch($sformatf("head_e%0d", i), head[i], e.head[i]);
            if (weight_self !== e.w_self)
               report_mismatch("weight_self", weight_self, e.w_self);
            if (weight_other !== e.w_other)
               report_mismatch("weight_other", weight_other, e.w_other);
         end
      end
   end

   task automatic send_pair(token_pair_type p);
      @(negedge clock);
      start <= 1'b1;
      for (int i = 0; i < EMBED_DIM; i++) begin
         tok0[i] <= p.tok0[i];
         tok1[i] <= p.tok1[i];
      end
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      expected_q.push_back(attend(p));
   endtask

   task automatic idle_cycles(int n);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   function automatic shortint rand_elem(bit wide);
      if (wide) return shortint'($urandom_range(0, 65535));
      return shortint'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic token_pair_type uniform_pair(shortint a, shortint b);
      token_pair_type p;
      foreach (p.tok0[i]) begin
         p.tok0[i] = a;
         p.tok1[i] = b;
      end
      return p;
   endfunction

   task automatic test_extremes();
      shortint vals [6] = '{0, 16384, -16384, 32767, -32768, 1};
      foreach (vals[a])
         foreach (vals[b])
            if (b % 2 == a % 2) send_pair(uniform_pair(vals[a], vals[b]));
   endtask

   task automatic test_equal_scores();
      token_pair_type p;
      for (int n = 0; n < 4; n++) begin
         foreach (p.tok0[i]) begin
            p.tok0[i] = rand_elem(0);
            p.tok1[i] = p.tok0[i];
         end
         send_pair(p);
      end
   endtask

   // large query against one key drives the other term to zero
   task automatic test_one_sided();
      send_pair(uniform_pair(32767, 0));
      send_pair(uniform_pair(-32768, 0));
      send_pair(uniform_pair(32767, -32768));
   endtask

   task automatic test_random(int count);
      token_pair_type p;
      int burst;
      bit wide, near, steady;
      while (count > 0) begin
         burst  = $urandom_range(1, 24);
         steady = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < burst && count > 0; n++, count--) begin
            wide = ($urandom_range(0, 4) == 0);
            near = ($urandom_range(0, 5) == 0);
            foreach (p.tok0[i]) begin
               p.tok0[i] = rand_elem(wide);
               p.tok1[i] = near ? shortint'(p.tok0[i] + int'($urandom_range(0, 8)) - 4)
                                : rand_elem(wide);
            end
            send_pair(p);
            if (!steady && $urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 3));
         end
         if (!steady) idle_cycles($urandom_range(0, 9));
      end
   endtask

   initial begin
      int waited;
      reset = 1'b1;
      start = 1'b0;
      foreach (tok0[i]) begin
         tok0[i] = '0;
         tok1[i] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_equal_scores();
      test_one_sided();
      test_random(1530);
      idle_cycles(1);

      waited = 0;
      while (expected_q.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_q.size() != 0)
         report_mismatch("transactions outstanding", expected_q.size(), 0);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
